// ----- design/sds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg: shared types and constants for the sort and dedupe set block
// Payload structs of both channels, the default capacity and the
// start command handed from the sequencer to the result buffer.
// ----------------------------------------------------------------------------
package sds_pkg;

	localparam int VALUE_W      = 32;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	// one element of the incoming set
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;

	// one distinct value of the outgoing run
	typedef struct packed {
		logic signed [VALUE_W-1:0] value_res;
		logic [COUNT_W-1:0]        unique_count;
		logic                      overflow;
		logic                      last_res;
	} result_t;

	// start of the output run, sent once all distinct values are buffered
	typedef struct packed {
		logic               start;
		logic [COUNT_W-1:0] count;
		logic               overflow;
	} emit_start_t;

endpackage

// ----- design/sort_and_dedupe_set.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sort_and_dedupe_set: sort a set of signed integers and drop duplicates
// Gathers up to CAPACITY elements, then emits the distinct values in
// ascending order, each tagged with the distinct count and overflow.
//
//   channel   direction  signals                          payload
//   item      in         item_valid / item_stall          item_t
//   result    out        result_valid / result_stall      result_t
//
// Loading takes one element per cycle until the element marked last.
// With n kept elements and u distinct values, the sort makes u + 1
// passes: each pass streams the element store through one signed
// comparator to find the next larger value. Output then runs at one
// transaction per cycle when not stalled, after a registered fetch.
// Reset clears the fill count and overflow flag; the stores need none.
// item_stall is high from the last element until the final result is taken.
// ----------------------------------------------------------------------------
module sort_and_dedupe_set import sds_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_LOAD = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]                state_q;
	logic [CW-1:0]             fill_q;
	logic [CW-1:0]             rd_idx_q;
	logic [CW-1:0]             ucnt_q;
	logic                      ovf_q;
	logic                      rd_vld_s1;
	logic                      rd_last_s1;
	logic signed [VALUE_W-1:0] rd_data;
	logic signed [VALUE_W-1:0] prev_q;
	logic signed [VALUE_W-1:0] best_q;
	logic                      have_prev_q;
	logic                      have_best_q;

	logic                      item_accept;
	logic                      room;
	logic                      issue;
	logic                      cand_hit;
	logic signed [VALUE_W-1:0] nxt_best;
	logic                      nxt_have;
	logic                      pass_end;
	emit_start_t               emit_cmd;
	logic                      emit_done;

	assign item_stall  = (state_q != S_LOAD);
	assign item_accept = item_valid && !item_stall;
	assign room        = (fill_q < CW'(CAPACITY));

	// scan read stream over the kept elements
	assign issue = (state_q == S_SCAN) && (rd_idx_q < fill_q);

	// shared comparator: smallest element above the previous distinct value
	assign cand_hit = rd_vld_s1
		&& (!have_prev_q || (rd_data > prev_q))
		&& (!have_best_q || (rd_data < best_q));
	assign nxt_best = cand_hit ? rd_data : best_q;
	assign nxt_have = have_best_q || cand_hit;
	assign pass_end = rd_vld_s1 && rd_last_s1;

	// start the output run when a pass finds nothing larger
	always_comb begin
		emit_cmd.start    = pass_end && !nxt_have;
		emit_cmd.count    = COUNT_W'(ucnt_q);
		emit_cmd.overflow = ovf_q;
	end

	sds_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (item_accept && room),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (item.value),
		.rd_en   (issue),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	sds_emit #(
		.CAPACITY (CAPACITY)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (pass_end && nxt_have),
		.wr_addr      (ucnt_q[AW-1:0]),
		.wr_data      (nxt_best),
		.cmd          (emit_cmd),
		.done         (emit_done),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// read pipeline tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else begin
			rd_vld_s1  <= issue;
			rd_last_s1 <= (rd_idx_q == fill_q - CW'(1));
		end
	end

	// comparison registers
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			best_q <= nxt_best;
			if (pass_end && nxt_have) begin
				prev_q <= nxt_best;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			rd_idx_q    <= '0;
			ucnt_q      <= '0;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (item_accept) begin
						if (room) begin
							fill_q <= fill_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last) begin
							state_q     <= S_SCAN;
							rd_idx_q    <= '0;
							ucnt_q      <= '0;
							have_prev_q <= 1'b0;
							have_best_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					// best candidate clears at the end of every pass
					have_best_q <= nxt_have && !pass_end;
					if (pass_end) begin
						if (nxt_have) begin
							ucnt_q      <= ucnt_q + CW'(1);
							have_prev_q <= 1'b1;
							rd_idx_q    <= '0;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (emit_done) begin
						state_q <= S_LOAD;
						fill_q  <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ----- design/sds_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_store: element store
// Holds the kept elements in arrival order. One write port, one read
// port with registered read data.
// ----------------------------------------------------------------------------
module sds_store import sds_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 wr_en,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0]   wr_addr,
	input  logic signed [VALUE_W-1:0]                            wr_data,
	input  logic                                                 rd_en,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0]   rd_addr,
	output logic signed [VALUE_W-1:0]                            rd_data
);

	logic signed [VALUE_W-1:0] mem_q [CAPACITY];
	logic signed [VALUE_W-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/sds_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_emit: result buffer and output stage
// Collects the distinct values in ascending order, then streams them
// out through an output register, one transaction per cycle when not
// stalled.
// ----------------------------------------------------------------------------
module sds_emit import sds_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 wr_en,
	input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0]   wr_addr,
	input  logic signed [VALUE_W-1:0]                            wr_data,
	input  emit_start_t                                          cmd,
	output logic                                                 done,
	output logic                                                 result_valid,
	input  logic                                                 result_stall,
	output result_t                                              result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [VALUE_W-1:0] mem_q [CAPACITY];
	logic signed [VALUE_W-1:0] rd_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             cnt_q;
	logic                      ovf_q;
	logic                      fetch_s1;
	logic                      fetch_last_s1;
	logic                      out_vld_q;
	result_t                   out_q;
	logic                      load;
	logic                      issue;

	// move fetched value into the output register when it is free
	assign load  = fetch_s1 && (!out_vld_q || !result_stall);
	// fetch the next value once the previous one has moved on
	assign issue = (idx_q < cnt_q) && (!fetch_s1 || load);
	assign done  = out_vld_q && !result_stall && out_q.last_res;

	// buffer memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_q          <= mem_q[idx_q[AW-1:0]];
			fetch_last_s1 <= (idx_q == cnt_q - CW'(1));
		end
	end

	// fetch control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			fetch_s1 <= 1'b0;
		end else begin
			fetch_s1 <= issue || (fetch_s1 && !load);
			if (cmd.start) begin
				idx_q <= '0;
				cnt_q <= CW'(cmd.count);
				ovf_q <= cmd.overflow;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.value_res    <= rd_q;
			out_q.unique_count <= COUNT_W'(cnt_q);
			out_q.overflow     <= ovf_q;
			out_q.last_res     <= fetch_last_s1;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule
